>>> design/bmorph_pkg.sv
// shared types and constants for the 2x2 binary morphology block
// no dependencies; used by bmorph_out_stage and binary_morphology_2x2_top
`default_nettype none

package bmorph_pkg;

  // pixel value that counts as on, and the value of an on result
  localparam logic [7:0] ON_VALUE  = 8'd255;
  localparam logic [7:0] OFF_VALUE = 8'd0;

  // configuration register indexes
  localparam logic [1:0] REG_MODE_DILATE  = 2'd0;
  localparam logic [1:0] REG_BORDER_ON    = 2'd1;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // one accepted item on its way to the result stage
  typedef struct packed {
    logic       flush;     // flush tick rather than pixel
    logic       cur;       // current pixel is on
    logic       pf;        // left-neighbor window result pending
    logic       ps;        // right-edge window result pending
    logic       b_border;  // second upper tap lies outside the frame
    logic       done;      // last result of the frame
    logic [7:0] row8;
    logic [7:0] col8;
  } stage_item_t;

  // 2x2 window: all on for erosion, any on for dilation
  function automatic logic win(input logic dilate, input logic a, input logic b,
                               input logic c, input logic d);
    win = dilate ? (a | b | c | d) : (a & b & c & d);
  endfunction

endpackage

`default_nettype wire

>>> design/bmorph_line_buf.sv
// one-bit line buffer: one write port and two registered read ports
// read-before-write on a shared address; no dependencies
`default_nettype none

module bmorph_line_buf #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic          wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr_a,
  input  wire logic [AW-1:0] rd_addr_b,
  output logic               rd_data_a,
  output logic               rd_data_b
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

>>> design/bmorph_out_stage.sv
// result stage: window logic on line buffer data, holds up to two results
// depends on bmorph_pkg
`default_nettype none

module bmorph_out_stage (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire bmorph_pkg::stage_item_t item,
  input  wire logic                    mem_a,
  input  wire logic                    mem_b,
  input  wire logic                    mode_dilate,
  input  wire logic                    border_on,
  output logic                         can_load,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [7:0]                   pixel_out,
  output logic [7:0]                   out_row,
  output logic [7:0]                   out_col,
  output logic                         last_of_run,
  output logic                         frame_done
);

  bmorph_pkg::stage_item_t ent;
  logic s1_valid;
  logic pend_first;
  logic pend_second;
  logic upper_left_on;
  logic left_pixel_on;
  logic out_acc;
  logic retire;
  logic on_bit;
  logic b_tap;

  assign out_valid = s1_valid && (pend_first || pend_second);
  assign out_acc   = out_valid && !out_stall;
  // the entry leaves after its last result, or at once when it has none
  assign retire    = s1_valid && (!(pend_first || pend_second) ||
                                  (out_acc && !(pend_first && pend_second)));
  assign can_load  = !s1_valid || retire;

  assign b_tap = ent.b_border ? border_on : mem_b;

  always_comb begin
    if (ent.flush) begin
      on_bit = bmorph_pkg::win(mode_dilate, mem_a, b_tap, border_on, border_on);
    end else if (pend_first) begin
      on_bit = bmorph_pkg::win(mode_dilate, upper_left_on, mem_a, left_pixel_on, ent.cur);
    end else begin
      on_bit = bmorph_pkg::win(mode_dilate, mem_a, border_on, ent.cur, border_on);
    end
  end

  assign pixel_out   = on_bit ? bmorph_pkg::ON_VALUE : bmorph_pkg::OFF_VALUE;
  assign out_row     = ent.row8;
  assign out_col     = (!ent.flush && pend_first) ? (ent.col8 - 8'd1) : ent.col8;
  assign last_of_run = !(pend_first && pend_second);
  assign frame_done  = ent.flush && ent.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      pend_first  <= 1'b0;
      pend_second <= 1'b0;
    end else begin
      if (out_acc) begin
        if (pend_first) begin
          pend_first <= 1'b0;
        end else begin
          pend_second <= 1'b0;
        end
      end
      if (load) begin
        s1_valid    <= 1'b1;
        pend_first  <= item.pf;
        pend_second <= item.ps;
      end else if (retire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_left_on <= 1'b0;
      left_pixel_on <= 1'b0;
    end else if (retire && !ent.flush) begin
      upper_left_on <= mem_a;
      left_pixel_on <= ent.cur;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= item;
    end
  end

endmodule

`default_nettype wire

>>> design/binary_morphology_2x2_top.sv
// top level of the 2x2 binary erosion / dilation block
// depends on bmorph_pkg, bmorph_line_buf and bmorph_out_stage
`default_nettype none

// Binary 2x2 erosion or dilation over a raster pixel stream. A pixel of 255
// is on; result (r,c) is 255 when the window (r,c),(r,c+1),(r+1,c),(r+1,c+1)
// is all on (erosion) or any on (dilation), window taps outside the frame
// take border_on. Results for row r come out while row r+1 arrives; the last
// row is released by flush items, one result per flush. Barring stalls, one
// item is taken per clock; the pixel that closes any row after the first
// carries two results when the frame is wider than one pixel, and so holds
// the input until its second result is taken, as the single result register
// delivers at most one result a clock. Items pass through two steps: the
// accept cycle, which reads and writes the one-bit line buffer, and the result
// register, which applies the window to the registered read data. Writing
// frame_width or frame_height restarts the frame; configuration is to be
// written only while idle, not enforced by the block. The line buffer needs
// no clearing pass: every entry is written before it is read for a result.
module binary_morphology_2x2_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration write port
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  // input items
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       kind,
  input  wire logic [7:0] pixel_in,
  // result items
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      pixel_out,
  output logic [7:0]      out_row,
  output logic [7:0]      out_col,
  output logic            last_of_run,
  output logic            frame_done
);

  // column index width, row count width, clamped dimension widths
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int HW0 = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = (WW0 > 9) ? WW0 : 9;
  localparam int HW  = (HW0 > 9) ? HW0 : 9;

  // configuration registers
  logic       mode_dilate;
  logic       border_on;
  logic [8:0] frame_width;
  logic [8:0] frame_height;

  // position counters
  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [CW-1:0] flush_count, flush_count_next;

  logic [WW-1:0] w, w_last;
  logic [HW-1:0] h;
  logic          c_is_last, fc_last;
  logic          pix_ok, flush_ok;
  logic          accept, take_pix, take_flush, load;
  logic          cur;
  logic          can_load;
  logic          mem_a, mem_b;
  logic          restart;
  bmorph_pkg::stage_item_t item;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_dilate  <= 1'b0;
      border_on    <= 1'b0;
      frame_width  <= 9'd200;
      frame_height <= 9'd200;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bmorph_pkg::REG_MODE_DILATE:  mode_dilate  <= cfg_data[0];
        bmorph_pkg::REG_BORDER_ON:    border_on    <= cfg_data[0];
        bmorph_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        bmorph_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  // a dimension of zero acts as one, any value above the maximum acts as the maximum
  always_comb begin
    if (frame_width == 9'd0) begin
      w = WW'(1);
    end else if (WW'(frame_width) > WW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width);
    end
    if (frame_height == 9'd0) begin
      h = HW'(1);
    end else if (HW'(frame_height) > HW'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height);
    end
  end

  assign w_last    = w - WW'(1);
  assign c_is_last = (WW'(column_count) == w_last);
  assign fc_last   = (WW'(flush_count) == w_last);

  // pixels after the last row and early flushes are dropped
  assign pix_ok   = (HW'(row_count) < h) && (WW'(column_count) < w);
  assign flush_ok = (HW'(row_count) >= h) && (WW'(flush_count) < w);

  assign in_stall   = !can_load;
  assign accept     = in_valid && !in_stall;
  assign take_pix   = accept && (kind == bmorph_pkg::KIND_PIXEL) && pix_ok;
  assign take_flush = accept && (kind == bmorph_pkg::KIND_FLUSH) && flush_ok;
  assign load       = take_pix || take_flush;
  assign cur        = (pixel_in == bmorph_pkg::ON_VALUE);

  assign restart = cfg_write && ((cfg_index == bmorph_pkg::REG_FRAME_WIDTH) ||
                                 (cfg_index == bmorph_pkg::REG_FRAME_HEIGHT));

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    flush_count_next  = flush_count;
    if (restart || (take_flush && fc_last)) begin
      column_count_next = '0;
      row_count_next    = '0;
      flush_count_next  = '0;
    end else if (take_pix) begin
      if (c_is_last) begin
        column_count_next = '0;
        row_count_next    = row_count + RW'(1);
      end else begin
        column_count_next = column_count + CW'(1);
      end
    end else if (take_flush) begin
      flush_count_next = flush_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      flush_count  <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      flush_count  <= flush_count_next;
    end
  end

  // what the result stage needs to know about this item
  always_comb begin
    item.flush    = take_flush;
    item.cur      = cur;
    item.b_border = fc_last;
    item.done     = fc_last;
    if (take_flush) begin
      item.pf   = 1'b1;
      item.ps   = 1'b0;
      item.row8 = 8'(h - HW'(1));
      item.col8 = 8'(flush_count);
    end else begin
      // row 0 only fills the line buffer
      item.pf   = (row_count != '0) && (column_count != '0);
      item.ps   = (row_count != '0) && c_is_last;
      item.row8 = 8'(row_count - RW'(1));
      item.col8 = 8'(column_count);
    end
  end

  // port a reads the tap above the pixel (or the first flush tap) while the
  // same edge overwrites it with the new pixel; port b reads the flush's right tap
  bmorph_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk       (clk),
    .wr_en     (take_pix),
    .wr_addr   (column_count),
    .wr_data   (cur),
    .rd_en     (load),
    .rd_addr_a (take_flush ? flush_count : column_count),
    .rd_addr_b (flush_count + CW'(1)),
    .rd_data_a (mem_a),
    .rd_data_b (mem_b)
  );

  bmorph_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .item        (item),
    .mem_a       (mem_a),
    .mem_b       (mem_b),
    .mode_dilate (mode_dilate),
    .border_on   (border_on),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run),
    .frame_done  (frame_done)
  );

endmodule

`default_nettype wire

>>> tb/binary_morphology_2x2_top_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the 2x2 binary erosion / dilation block
// depends on bmorph_pkg and binary_morphology_2x2_top; reads no files

module binary_morphology_2x2_top_test;

  localparam int FRAME_MAX     = 256;
  localparam int SETTLE_CYCLES = 6;        // two-step pipe, plus margin
  localparam int FINAL_WAIT    = 20;
  localparam int HOLD_CYCLES   = 64;       // long receiver hold-off
  localparam int RANDOM_ITEMS  = 1600;
  localparam int TIMEOUT_NS    = 5_000_000;

  // one result pixel as it leaves the block
  typedef struct packed {
    logic [7:0] pix;
    logic [7:0] row;
    logic [7:0] col;
    logic       last;
    logic       done;
  } morph_result_t;

  // one row of the directed table: a register write or an item
  typedef struct packed {
    logic          is_cfg;
    logic [1:0]    reg_idx;
    logic [8:0]    reg_data;
    logic          kind_v;
    logic [7:0]    pix;
    logic          typed;    // expected result given in the row
    morph_result_t want;
  } stim_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  localparam morph_result_t NO_RESULT = '0;

  // directed part: small frames, extremes of sizes and pixels, ignored items
  stim_row_t directed_rows [33] = '{
    // erosion, border off, 2x2 frame of all-on pixels
    '{1'b1, bmorph_pkg::REG_MODE_DILATE, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b1, bmorph_pkg::REG_BORDER_ON, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b1, bmorph_pkg::REG_FRAME_WIDTH, 9'd2, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b1, bmorph_pkg::REG_FRAME_HEIGHT, 9'd2, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd255, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd255, 1'b0, NO_RESULT},
    // flush before the rows are complete: ignored
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_FLUSH, 8'd0, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd255, 1'b0, NO_RESULT},
    // closes the last row: two results
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd255, 1'b0, NO_RESULT},
    // pixel after the last row: ignored
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_FLUSH, 8'd0, 1'b1,
      '{bmorph_pkg::OFF_VALUE, 8'd1, 8'd0, 1'b1, 1'b0}},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_FLUSH, 8'd0, 1'b1,
      '{bmorph_pkg::OFF_VALUE, 8'd1, 8'd1, 1'b1, 1'b1}},
    // flush after the frame closed: ignored
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_FLUSH, 8'd0, 1'b0, NO_RESULT},
    // dilation, border on, zero sizes taken as 1x1
    '{1'b1, bmorph_pkg::REG_MODE_DILATE, 9'd1, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b1, bmorph_pkg::REG_BORDER_ON, 9'd1, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b1, bmorph_pkg::REG_FRAME_WIDTH, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b1, bmorph_pkg::REG_FRAME_HEIGHT, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_FLUSH, 8'd0, 1'b1,
      '{bmorph_pkg::ON_VALUE, 8'd0, 8'd0, 1'b1, 1'b1}},
    // erosion, border on, 3x2 with near-on pixels
    '{1'b1, bmorph_pkg::REG_MODE_DILATE, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b1, bmorph_pkg::REG_FRAME_WIDTH, 9'd3, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b1, bmorph_pkg::REG_FRAME_HEIGHT, 9'd2, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd255, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd254, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd255, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd255, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd1, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_PIXEL, 8'd255, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_FLUSH, 8'd0, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_FLUSH, 8'd0, 1'b0, NO_RESULT},
    '{1'b0, 2'd0, 9'd0, bmorph_pkg::KIND_FLUSH, 8'd0, 1'b1,
      '{bmorph_pkg::ON_VALUE, 8'd1, 8'd2, 1'b1, 1'b1}},
    // oversize values, clamped to the maximum
    '{1'b1, bmorph_pkg::REG_FRAME_WIDTH, 9'd511, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT},
    '{1'b1, bmorph_pkg::REG_FRAME_HEIGHT, 9'd511, bmorph_pkg::KIND_PIXEL, 8'd0, 1'b0, NO_RESULT}
  };

  // dut ports
  logic       clk;
  logic       rst       = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic       kind      = bmorph_pkg::KIND_PIXEL;
  logic [7:0] pixel_in  = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] pixel_out;
  logic [7:0] out_row;
  logic [7:0] out_col;
  logic       last_of_run;
  logic       frame_done;

  // shadow copy of the block: registers, line buffer and position counters
  logic       dilate_on  = 1'b0;
  logic       border_bit = 1'b0;
  logic [8:0] width_reg  = 9'd200;
  logic [8:0] height_reg = 9'd200;
  logic       line_bits [FRAME_MAX];
  logic       left_on    = 1'b0;
  logic       upleft_on  = 1'b0;
  int         col_pos    = 0;
  int         row_pos    = 0;
  int         flush_pos  = 0;

  morph_result_t expected_px[$];   // results still owed by the block
  int items_used  = 0;             // items that the block acted on
  int fail_count  = 0;
  int burst_left  = 0;

  // receiver state
  int           holdoffs_asked   = 0;
  int           holdoffs_granted = 0;
  int           hold_left        = 0;
  int           style_left       = 0;
  int           stall_beat       = 0;
  stall_style_t stall_style      = STALL_NONE;

  binary_morphology_2x2_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .pixel_in    (pixel_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run),
    .frame_done  (frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // size registers: 0 acts as 1, anything above the maximum as the maximum
  function automatic int eff_size(input logic [8:0] v);
    if (v == 9'd0) return 1;
    if (v > FRAME_MAX) return FRAME_MAX;
    return int'(v);
  endfunction

  function automatic logic [7:0] morph_window(input logic a, input logic b,
                                              input logic c, input logic d);
    logic hit;
    hit = dilate_on ? (a | b | c | d) : (a & b & c & d);
    return hit ? bmorph_pkg::ON_VALUE : bmorph_pkg::OFF_VALUE;
  endfunction

  function automatic void restart_frame();
    left_on   = 1'b0;
    upleft_on = 1'b0;
    col_pos   = 0;
    row_pos   = 0;
    flush_pos = 0;
  endfunction

  // advance the shadow state by one item; returns the number of results
  function automatic int predict_morph(input logic k, input logic [7:0] p,
                                       output morph_result_t res [2]);
    int   w;
    int   h;
    int   n;
    logic cur;
    logic up;
    logic b_tap;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    n = 0;
    res[0] = NO_RESULT;
    res[1] = NO_RESULT;
    if (k == bmorph_pkg::KIND_FLUSH) begin
      // flushes count only once every row is in, one per column
      if (row_pos < h || flush_pos >= w) return 0;
      b_tap  = (flush_pos + 1 < w) ? line_bits[flush_pos + 1] : border_bit;
      res[0] = '{morph_window(line_bits[flush_pos], b_tap, border_bit, border_bit),
                 8'(h - 1), 8'(flush_pos), 1'b1, flush_pos == w - 1};
      if (flush_pos == w - 1) restart_frame();
      else flush_pos++;
      items_used++;
      return 1;
    end
    // pixels past the last row wait for the flushes and are dropped
    if (row_pos >= h || col_pos >= w) return 0;
    cur = (p == bmorph_pkg::ON_VALUE);
    up  = line_bits[col_pos];
    if (row_pos >= 1) begin
      if (col_pos >= 1) begin
        res[n] = '{morph_window(upleft_on, up, left_on, cur),
                   8'(row_pos - 1), 8'(col_pos - 1), 1'b0, 1'b0};
        n++;
      end
      // right edge: the outside column comes from the border value
      if (col_pos == w - 1) begin
        res[n] = '{morph_window(up, border_bit, cur, border_bit),
                   8'(row_pos - 1), 8'(col_pos), 1'b0, 1'b0};
        n++;
      end
    end
    line_bits[col_pos] = cur;
    upleft_on = up;
    left_on   = cur;
    if (col_pos == w - 1) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    if (n > 0) res[n - 1].last = 1'b1;
    items_used++;
    return n;
  endfunction

  // register write; the trailing wait keeps two writes from touching the
  // enable in the same step
  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      bmorph_pkg::REG_MODE_DILATE:  dilate_on  = data[0];
      bmorph_pkg::REG_BORDER_ON:    border_bit = data[0];
      bmorph_pkg::REG_FRAME_WIDTH:  begin
        width_reg = data;
        restart_frame();
      end
      bmorph_pkg::REG_FRAME_HEIGHT: begin
        height_reg = data;
        restart_frame();
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop offering items, wait for every owed result, then let the pipe empty
  task automatic settle_idle(input int extra);
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // offer one item in the sender's burst pattern and record what it owes
  task automatic send_item(input logic k, input logic [7:0] p, input logic typed,
                           input morph_result_t want);
    morph_result_t got [2];
    int n;
    int gap;
    int j;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    kind     <= k;
    pixel_in <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = predict_morph(k, p, got);
    // a typed row replaces the prediction by its own expectation
    if (typed) expected_px.push_back(want);
    else for (j = 0; j < n; j++) expected_px.push_back(got[j]);
  endtask

  // one frame with random content, laced with a little noise and now and then abandoned
  task automatic send_frame(input int w, input int h, input int pause_at,
                            input int hold_at);
    int idx;
    int f;
    int on_pct;
    logic [7:0] p;
    on_pct = $urandom_range(0, 100);
    for (idx = 0; idx < w * h; idx++) begin
      if (idx == hold_at) holdoffs_asked <= holdoffs_asked + 1;
      if (idx == pause_at) begin
        // sender waits for the block to drain, then maybe retunes mid-frame
        settle_idle(SETTLE_CYCLES);
        if ($urandom_range(0, 1) == 1) begin
          write_reg(bmorph_pkg::REG_MODE_DILATE, 9'($urandom));
        end
        if ($urandom_range(0, 1) == 1) begin
          write_reg(bmorph_pkg::REG_BORDER_ON, 9'($urandom));
        end
      end
      // early flush, ignored by the block
      if ($urandom_range(0, 59) == 0) begin
        send_item(bmorph_pkg::KIND_FLUSH, 8'($urandom), 1'b0, NO_RESULT);
      end
      if ($urandom_range(0, 99) < on_pct) p = bmorph_pkg::ON_VALUE;
      else p = 8'($urandom_range(0, 254));
      send_item(bmorph_pkg::KIND_PIXEL, p, 1'b0, NO_RESULT);
      // abandoned frame: the stream just carries on where it stopped
      if ($urandom_range(0, 199) == 0) return;
    end
    // stray pixel while the last row waits for its flushes
    if ($urandom_range(0, 7) == 0) begin
      send_item(bmorph_pkg::KIND_PIXEL, 8'($urandom), 1'b0, NO_RESULT);
    end
    for (f = 0; f < w; f++) begin
      send_item(bmorph_pkg::KIND_FLUSH, 8'($urandom), 1'b0, NO_RESULT);
    end
    // flush after the frame closed
    if ($urandom_range(0, 7) == 0) begin
      send_item(bmorph_pkg::KIND_FLUSH, 8'($urandom), 1'b0, NO_RESULT);
    end
  endtask

  // main stimulus: reset, directed table, then random frames
  initial begin : stimulus
    int phase_no;
    int w_cfg;
    int h_cfg;
    int w;
    int h;
    int nf;
    int f;
    int pause_at;
    int hold_at;
    int random_start;
    phase_no = 0;
    foreach (line_bits[i]) line_bits[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle_idle(SETTLE_CYCLES);
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_item(directed_rows[i].kind_v, directed_rows[i].pix,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    random_start = items_used;
    while (items_used - random_start < RANDOM_ITEMS) begin
      phase_no++;
      settle_idle(SETTLE_CYCLES);
      if (phase_no == 2) begin
        // widest row, oversize value
        w_cfg = $urandom_range(257, 511);
        h_cfg = 2;
      end else if (phase_no == 5) begin
        // single column, tallest frame
        w_cfg = 1;
        h_cfg = $urandom_range(256, 511);
      end else begin
        w_cfg = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 9);
        h_cfg = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
      end
      write_reg(bmorph_pkg::REG_MODE_DILATE, 9'($urandom));
      write_reg(bmorph_pkg::REG_BORDER_ON, 9'($urandom));
      write_reg(bmorph_pkg::REG_FRAME_WIDTH, 9'(w_cfg));
      write_reg(bmorph_pkg::REG_FRAME_HEIGHT, 9'(h_cfg));
      w  = eff_size(width_reg);
      h  = eff_size(height_reg);
      nf = (w * h > 64) ? 1 : $urandom_range(1, 3);
      for (f = 0; f < nf; f++) begin
        if (phase_no == 2) begin
          // receiver holds off early in the second row, sender pauses later
          hold_at  = w + 10;
          pause_at = w + w / 2;
        end else begin
          hold_at  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, w * h - 1) : -1;
          pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, w * h - 1) : -1;
        end
        send_frame(w, h, pause_at, hold_at);
      end
    end

    settle_idle(FINAL_WAIT);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver: changing stall styles, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall        <= 1'b0;
      stall_style      <= STALL_NONE;
      style_left       <= 0;
      hold_left        <= 0;
      holdoffs_granted <= 0;
      stall_beat       <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holdoffs_granted != holdoffs_asked) begin
      out_stall        <= 1'b1;
      hold_left        <= HOLD_CYCLES - 1;
      holdoffs_granted <= holdoffs_granted + 1;
    end else begin
      stall_beat <= stall_beat + 1;
      if (style_left == 0) begin
        stall_style <= stall_style_t'($urandom_range(0, 3));
        style_left  <= $urandom_range(20, 200);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (stall_beat % 3 == 0);
      endcase
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    morph_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_px.size() == 0) begin
        $error("unexpected result: row %0d col %0d pixel %0d", out_row, out_col, pixel_out);
        fail_count++;
      end else begin
        want = expected_px.pop_front();
        check_field("pixel_out", want.pix, pixel_out);
        check_field("out_row", want.row, out_row);
        check_field("out_col", want.col, out_col);
        check_field("last_of_run", want.last, last_of_run);
        check_field("frame_done", want.done, frame_done);
      end
    end
  end

endmodule

>>> binary_morphology_2x2_top.f
design/bmorph_pkg.sv
design/bmorph_line_buf.sv
design/bmorph_out_stage.sv
design/binary_morphology_2x2_top.sv
tb/binary_morphology_2x2_top_test.sv
